// File: src/mcsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Machine CSR and trap unit package
// Beat types, operation codes, CSR addresses and field positions shared by
// the CSR file and the top level.
// ----------------------------------------------------------------------------
package mcsr_pkg;

   // Operation codes carried in the mode field.
   localparam logic [2:0] MODE_READ  = 3'd0;
   localparam logic [2:0] MODE_WRITE = 3'd1;
   localparam logic [2:0] MODE_TRAP  = 3'd2;
   localparam logic [2:0] MODE_CHECK = 3'd3;
   localparam logic [2:0] MODE_TIMER = 3'd4;

   // Supported CSR addresses.
   localparam logic [11:0] ADDR_MSTATUS = 12'h300;
   localparam logic [11:0] ADDR_MIE     = 12'h304;
   localparam logic [11:0] ADDR_MTVEC   = 12'h305;
   localparam logic [11:0] ADDR_MEPC    = 12'h341;
   localparam logic [11:0] ADDR_MCAUSE  = 12'h342;
   localparam logic [11:0] ADDR_MTVAL   = 12'h343;
   localparam logic [11:0] ADDR_MIP     = 12'h344;

   // Bit positions inside mstatus, mie and mip.
   localparam int BIT_MIE  = 3;
   localparam int BIT_MPIE = 7;
   localparam int BIT_MPP0 = 11;
   localparam int BIT_MPP1 = 12;
   localparam int BIT_MTIE = 7;
   localparam int BIT_MTIP = 7;

   // Cause recorded for the machine timer interrupt.
   localparam logic [31:0] TIMER_CAUSE = 32'h8000_0007;

   // Request beat.
   typedef struct packed {
      logic [2:0]  mode;
      logic [11:0] csr_address;
      logic [31:0] write_value;
      logic [31:0] trap_cause;
      logic [31:0] trap_value;
      logic [31:0] current_pc;
      logic        timer_pending;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic [31:0] read_data;
      logic        bad_address;
      logic        trap_taken;
      logic        interrupt_taken;
      logic [31:0] next_pc;
   } rsp_type;

endpackage

// File: src/mcsr_file.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Machine CSR file
// Holds mtvec, mepc, mcause, mtval, mstatus, mie and MTIP. Computes the
// response for one request and updates the registers when execute is high.
// ----------------------------------------------------------------------------
module mcsr_file (
   input  logic             clock,
   input  logic             reset,
   input  logic             execute,
   input  mcsr_pkg::req_type item,
   output mcsr_pkg::rsp_type result
);

   // Only the bits that can ever be nonzero are stored.
   logic [29:0] mtvec_ff,  mtvec_in;
   logic [29:0] mepc_ff,   mepc_in;
   logic [31:0] mcause_ff, mcause_in;
   logic [31:0] mtval_ff,  mtval_in;
   logic        mie_ff,    mie_in;
   logic        mpie_ff,   mpie_in;
   logic        mpp_ff,    mpp_in;
   logic        mtie_ff,   mtie_in;
   logic        mtip_ff,   mtip_in;

   logic [31:0] mstatus_value;
   logic [31:0] mie_value;
   logic [31:0] mip_value;
   logic [31:0] mtvec_value;
   logic        irq_ready;

   // Full-width views of the packed registers.
   always_comb begin
      mstatus_value = '0;
      mstatus_value[mcsr_pkg::BIT_MIE]  = mie_ff;
      mstatus_value[mcsr_pkg::BIT_MPIE] = mpie_ff;
      mstatus_value[mcsr_pkg::BIT_MPP0] = mpp_ff;
      mstatus_value[mcsr_pkg::BIT_MPP1] = mpp_ff;
      mie_value = '0;
      mie_value[mcsr_pkg::BIT_MTIE] = mtie_ff;
      mip_value = '0;
      mip_value[mcsr_pkg::BIT_MTIP] = mtip_ff;
      mtvec_value = {mtvec_ff, 2'b00};
   end

   assign irq_ready = mie_ff & mtie_ff & mtip_ff;

   // Response and next register values for the current request.
   always_comb begin
      result    = '0;
      mtvec_in  = mtvec_ff;
      mepc_in   = mepc_ff;
      mcause_in = mcause_ff;
      mtval_in  = mtval_ff;
      mie_in    = mie_ff;
      mpie_in   = mpie_ff;
      mpp_in    = mpp_ff;
      mtie_in   = mtie_ff;
      mtip_in   = mtip_ff;
      case (item.mode)
         mcsr_pkg::MODE_READ: begin
            case (item.csr_address)
               mcsr_pkg::ADDR_MTVEC:   result.read_data = mtvec_value;
               mcsr_pkg::ADDR_MEPC:    result.read_data = {mepc_ff, 2'b00};
               mcsr_pkg::ADDR_MCAUSE:  result.read_data = mcause_ff;
               mcsr_pkg::ADDR_MTVAL:   result.read_data = mtval_ff;
               mcsr_pkg::ADDR_MSTATUS: result.read_data = mstatus_value;
               mcsr_pkg::ADDR_MIP:     result.read_data = mip_value;
               mcsr_pkg::ADDR_MIE:     result.read_data = mie_value;
               default:                result.bad_address = 1'b1;
            endcase
         end
         mcsr_pkg::MODE_WRITE: begin
            case (item.csr_address)
               mcsr_pkg::ADDR_MTVEC:  mtvec_in  = item.write_value[31:2];
               mcsr_pkg::ADDR_MEPC:   mepc_in   = item.write_value[31:2];
               mcsr_pkg::ADDR_MCAUSE: mcause_in = item.write_value;
               mcsr_pkg::ADDR_MTVAL:  mtval_in  = item.write_value;
               mcsr_pkg::ADDR_MSTATUS: begin
                  mie_in  = item.write_value[mcsr_pkg::BIT_MIE];
                  mpie_in = item.write_value[mcsr_pkg::BIT_MPIE];
                  mpp_in  = 1'b1;
               end
               mcsr_pkg::ADDR_MIP: begin
                  // The pending bit follows the timer level only.
               end
               mcsr_pkg::ADDR_MIE:    mtie_in = item.write_value[mcsr_pkg::BIT_MTIE];
               default:               result.bad_address = 1'b1;
            endcase
         end
         mcsr_pkg::MODE_TRAP: begin
            mepc_in           = item.current_pc[31:2];
            mcause_in         = item.trap_cause;
            mtval_in          = item.trap_value;
            mpie_in           = mie_ff;
            mie_in            = 1'b0;
            result.trap_taken = 1'b1;
            result.next_pc    = mtvec_value;
         end
         mcsr_pkg::MODE_CHECK: begin
            if (irq_ready) begin
               mepc_in                = item.current_pc[31:2];
               mcause_in              = mcsr_pkg::TIMER_CAUSE;
               mtval_in               = '0;
               mpie_in                = mie_ff;
               mie_in                 = 1'b0;
               result.trap_taken      = 1'b1;
               result.interrupt_taken = 1'b1;
               result.next_pc         = mtvec_value;
            end
         end
         mcsr_pkg::MODE_TIMER: mtip_in = item.timer_pending;
         default: begin
            // Unused modes leave everything as it is.
         end
      endcase
   end

   // Register update, one request per cycle while execute is high.
   always_ff @(posedge clock) begin
      if (reset) begin
         mtvec_ff  <= '0;
         mepc_ff   <= '0;
         mcause_ff <= '0;
         mtval_ff  <= '0;
         mie_ff    <= 1'b0;
         mpie_ff   <= 1'b0;
         mpp_ff    <= 1'b0;
         mtie_ff   <= 1'b0;
         mtip_ff   <= 1'b0;
      end else if (execute) begin
         mtvec_ff  <= mtvec_in;
         mepc_ff   <= mepc_in;
         mcause_ff <= mcause_in;
         mtval_ff  <= mtval_in;
         mie_ff    <= mie_in;
         mpie_ff   <= mpie_in;
         mpp_ff    <= mpp_in;
         mtie_ff   <= mtie_in;
         mtip_ff   <= mtip_in;
      end
   end

endmodule

// File: src/machine_csr_trap_unit.sv
`timescale 1ns / 1ps
// A request beat is held in the request register, and its response beat in the response register.
// Throughput: one request per cycle while rsp_stall is low; the request register, the CSR update and the
// response register form a two-stage pipeline that only halts when rsp_stall holds.
// Reset clears both stage valid flags and every CSR, including MTIP, to zero.
// ----------------------------------------------------------------------------
// Machine CSR and trap unit
// RISC-V machine-mode CSR file with trap entry and machine timer interrupt
// check, behind a request register and a response register.
// ----------------------------------------------------------------------------
module machine_csr_trap_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mcsr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mcsr_pkg::rsp_type rsp_data
);

   logic              req_valid_ff;
   mcsr_pkg::req_type req_data_ff;
   logic              rsp_valid_ff;
   mcsr_pkg::rsp_type rsp_data_ff;
   mcsr_pkg::rsp_type rsp_data_in;
   logic              advance;

   // The request stage moves on whenever the response register is free.
   assign advance   = req_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = req_valid_ff & ~advance;

   // CSR state and the response logic.
   mcsr_file u_file (
      .clock   (clock),
      .reset   (reset),
      .execute (advance),
      .item    (req_data_ff),
      .result  (rsp_data_in)
   );

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (~req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (~req_stall && req_valid) begin
         req_data_ff <= req_data;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (~rsp_valid_ff || ~rsp_stall) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
